// File: rtl/core/lpmf_pkg.sv
// Shared constants and types for the lidar point mask filter.
// No dependencies; imported by lidar_point_mask_filter_unit.
package lpmf_pkg;

    localparam int CW = 32;  // coordinate and box bound width

    // tan(angle) * 2^30 for the azimuth sector edges
    localparam logic [29:0] TAN_ARM   = 30'd141360793;  // 7.5 deg
    localparam logic [29:0] TAN_BODY  = 30'd751842119;  // 35 deg
    localparam logic [29:0] TAN_BASE  = 30'd359270305;  // 18.5 deg
    localparam logic [29:0] TAN_CABLE = 30'd444758426;  // 180 - 157.5 deg

    // tan^2(elevation) * 2^30
    localparam logic [27:0] TSQ_BODY  = 28'd233477463;  // 25 deg
    localparam logic [27:0] TSQ_BASE  = 28'd66748573;   // 14 deg
    localparam logic [27:0] TSQ_CABLE = 28'd142243227;  // 20 deg

    typedef enum logic [2:0] {
        REASON_KEPT      = 3'd0,
        REASON_NOT_READY = 3'd1,
        REASON_ARM       = 3'd2,
        REASON_BODY      = 3'd3,
        REASON_BASE      = 3'd4,
        REASON_CABLE     = 3'd5,
        REASON_BOX       = 3'd6
    } reason_t;

    localparam logic [2:0] REG_ARM_STOWED = 3'd0;
    localparam logic [2:0] REG_BOX_READY  = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_X  = 3'd2;
    localparam logic [2:0] REG_BOX_MIN_Y  = 3'd3;
    localparam logic [2:0] REG_BOX_MIN_Z  = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_X  = 3'd5;
    localparam logic [2:0] REG_BOX_MAX_Y  = 3'd6;
    localparam logic [2:0] REG_BOX_MAX_Z  = 3'd7;

endpackage

// File: rtl/core/lidar_point_mask_filter_unit.sv
// Lidar point mask filter: angular sector masks plus ray/box slab test.
// Depends on lpmf_pkg.
//
// Usage:
//   s_* channel takes one point request per beat: s_tdata holds pos_x,
//   pos_y, pos_z (signed Q15.16) and point_tag. m_* channel returns one
//   result per point, in order: keep, drop_reason, tag_out.
//   APB port holds the arm state and the arm bounding box; write it only
//   while no point is in flight.
// Throughput: one point per clock. The work is an 8-register pipeline:
//   input capture, magnitudes/slab bounds, squares and tangent products,
//   azimuth compares and axis-1 slab merge, elevation partial products and
//   axis-2 slab products, elevation compares and axis-2 merge, final slab
//   cross products, and the result register.
// Stall: the whole pipe advances only when the result register is empty or
//   being taken (s_tready = !m_tvalid || m_tready), so a stalled receiver
//   freezes every stage and nothing is lost or repeated.
// Reset (aresetn low, synchronous): all stage valid bits clear; arm_stowed
//   goes to 1, box_ready to 0, box bounds to 0.
module lidar_point_mask_filter_unit
    import lpmf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], point_tag[111:96]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,
    // m_tdata: keep[0], drop_reason[3:1], tag_out[19:4], zero pad[23:20]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // ---------------- configuration registers ----------------
    logic                 arm_stowed_reg, box_ready_reg;
    logic signed [CW-1:0] box_min_reg [3];
    logic signed [CW-1:0] box_max_reg [3];
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_stowed_reg <= 1'b1;
            box_ready_reg  <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_ARM_STOWED: arm_stowed_reg <= pwdata[0];
                REG_BOX_READY:  box_ready_reg  <= pwdata[0];
                REG_BOX_MIN_X:  box_min_reg[0] <= pwdata;
                REG_BOX_MIN_Y:  box_min_reg[1] <= pwdata;
                REG_BOX_MIN_Z:  box_min_reg[2] <= pwdata;
                REG_BOX_MAX_X:  box_max_reg[0] <= pwdata;
                REG_BOX_MAX_Y:  box_max_reg[1] <= pwdata;
                REG_BOX_MAX_Z:  box_max_reg[2] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_ARM_STOWED: prdata = {31'd0, arm_stowed_reg};
            REG_BOX_READY:  prdata = {31'd0, box_ready_reg};
            REG_BOX_MIN_X:  prdata = box_min_reg[0];
            REG_BOX_MIN_Y:  prdata = box_min_reg[1];
            REG_BOX_MIN_Z:  prdata = box_min_reg[2];
            REG_BOX_MAX_X:  prdata = box_max_reg[0];
            REG_BOX_MAX_Y:  prdata = box_max_reg[1];
            REG_BOX_MAX_Z:  prdata = box_max_reg[2];
        endcase
    end

    // ---------------- pipeline control ----------------
    logic       adv;
    logic [7:0] vld_reg;  // stage valid bits, [7] is the result register

    assign adv      = !vld_reg[7] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[7];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[6:0], s_tvalid};
        end
    end

    // ---------------- S0: capture ----------------
    logic signed [CW-1:0] s0_p_reg [3];
    logic [15:0]          tag_reg [8];

    // ---------------- S1: magnitudes, slab bounds ----------------
    logic [CW-1:0]        s1_ax_next, s1_ay_next, s1_az_next;
    logic [CW-1:0]        s1_ax_reg, s1_ay_reg, s1_az_reg;
    logic signed [CW:0]   s1_lo_next [3], s1_hi_next [3];
    logic signed [CW:0]   s1_lo_reg [3], s1_hi_reg [3];
    logic [CW-1:0]        s1_den_next [3], s1_den_reg [3];
    logic [2:0]           s1_zero_next, s1_zero_reg;
    logic                 s1_miss_next;
    logic                 s1_xpos_reg, s1_xneg_reg, s1_zneg_reg;
    logic [7:1]           miss_reg;  // zero-component miss flag per stage

    always_comb begin
        logic signed [CW:0] mn, mx, n1, n2;
        logic               dpos;
        s1_ax_next   = s0_p_reg[0][CW-1] ? ('0 - s0_p_reg[0]) : s0_p_reg[0];
        s1_ay_next   = s0_p_reg[1][CW-1] ? ('0 - s0_p_reg[1]) : s0_p_reg[1];
        s1_az_next   = s0_p_reg[2][CW-1] ? ('0 - s0_p_reg[2]) : s0_p_reg[2];
        s1_miss_next = 1'b0;
        for (int a = 0; a < 3; a++) begin
            mn   = {box_min_reg[a][CW-1], box_min_reg[a]};
            mx   = {box_max_reg[a][CW-1], box_max_reg[a]};
            dpos = !s0_p_reg[a][CW-1];
            n1   = dpos ? mn : -mn;
            n2   = dpos ? mx : -mx;
            s1_lo_next[a]   = (n1 < n2) ? n1 : n2;
            s1_hi_next[a]   = (n1 < n2) ? n2 : n1;
            s1_den_next[a]  = s0_p_reg[a][CW-1] ? ('0 - s0_p_reg[a]) : s0_p_reg[a];
            s1_zero_next[a] = (s0_p_reg[a] == '0);
            // zero ray component with the origin outside this slab: miss
            if (s1_zero_next[a] && (box_min_reg[a] > 0 || box_max_reg[a] < 0)) begin
                s1_miss_next = 1'b1;
            end
        end
    end

    // ---------------- S2: squares, tangent products, axis-1 slab products ----
    logic [63:0]          s2_xx_reg, s2_yy_reg, s2_zz_reg;
    logic [61:0]          s2_tarm_reg, s2_tbody_reg, s2_tbase_reg, s2_tcable_reg;
    logic [CW-1:0]        s2_ay_reg;
    logic signed [CW:0]   s2_ln_reg, s2_hn_reg;
    logic [CW-1:0]        s2_ld_reg, s2_hd_reg;
    logic                 s2_inf_reg;
    logic signed [65:0]   s2_pla_reg, s2_plb_reg, s2_pha_reg, s2_phb_reg;
    logic                 s2_xpos_reg, s2_xneg_reg, s2_zneg_reg, s2_xyzero_reg;

    // carried slab data for axes 1 and 2
    logic signed [CW:0] s2_lo_reg [3], s2_hi_reg [3], s3_lo2_reg, s3_hi2_reg;
    logic [CW-1:0]      s2_den_reg [3], s3_den2_reg;
    logic [2:0]         s2_zero_reg;
    logic               s3_zero2_reg;

    // ---------------- S3: azimuth flags, rr, axis-1 merge ----------------
    logic                 s3_aarm_next, s3_abody_next, s3_abase_next, s3_acable_next;
    logic                 s3_aarm_reg, s3_abody_reg, s3_abase_reg, s3_acable_reg;
    logic [63:0]          s3_rr_reg, s3_zz_reg;
    logic signed [CW:0]   s3_ln_next, s3_hn_next, s3_ln_reg, s3_hn_reg;
    logic [CW-1:0]        s3_ld_next, s3_hd_next, s3_ld_reg, s3_hd_reg;
    logic                 s3_inf_reg;
    logic                 s3_xpos_reg, s3_xneg_reg, s3_zneg_reg, s3_xyzero_reg;

    logic [61:0] ay30;
    assign ay30           = {s2_ay_reg, 30'd0};
    assign s3_aarm_next   = ay30 < s2_tarm_reg;
    assign s3_abody_next  = ay30 < s2_tbody_reg;
    assign s3_abase_next  = ay30 < s2_tbase_reg;
    assign s3_acable_next = ay30 < s2_tcable_reg;

    always_comb begin
        logic tl, th;
        tl = !s2_zero_reg[1] && (s2_inf_reg || (s2_pla_reg < s2_plb_reg));
        th = !s2_zero_reg[1] && (s2_inf_reg || (s2_pha_reg < s2_phb_reg));
        s3_ln_next = tl ? s2_lo_reg[1] : s2_ln_reg;
        s3_ld_next = tl ? s2_den_reg[1] : s2_ld_reg;
        s3_hn_next = th ? s2_hi_reg[1] : s2_hn_reg;
        s3_hd_next = th ? s2_den_reg[1] : s2_hd_reg;
    end

    // ---------------- S4: elevation partial products, axis-2 slab products ----
    logic [59:0]        s4_pbh_reg, s4_pbl_reg, s4_pah_reg, s4_pal_reg;
    logic [59:0]        s4_pch_reg, s4_pcl_reg;
    logic [63:0]        s4_zz_reg;
    logic signed [CW:0] s4_ln_reg, s4_hn_reg, s4_lo2_reg, s4_hi2_reg;
    logic [CW-1:0]      s4_ld_reg, s4_hd_reg, s4_den2_reg;
    logic               s4_inf_reg, s4_zero2_reg;
    logic signed [65:0] s4_pla_reg, s4_plb_reg, s4_pha_reg, s4_phb_reg;
    logic [3:0]         s4_az_reg;  // arm, body, base, cable
    logic [3:0]         s4_sg_reg;  // xpos, xneg, zneg, x=y=0

    // ---------------- S5: elevation flags, axis-2 merge ----------------
    logic [91:0]        prod_body, prod_base, prod_cable;
    logic [93:0]        zz30;
    logic [2:0]         s5_el_reg;  // body, base, cable
    logic [3:0]         s5_az_reg, s5_sg_reg;
    logic signed [CW:0] s5_ln_next, s5_hn_next, s5_ln_reg, s5_hn_reg;
    logic [CW-1:0]      s5_ld_next, s5_hd_next, s5_ld_reg, s5_hd_reg;
    logic               s5_inf_reg;

    assign prod_body  = {s4_pbh_reg, 32'd0} + {32'd0, s4_pbl_reg};
    assign prod_base  = {s4_pah_reg, 32'd0} + {32'd0, s4_pal_reg};
    assign prod_cable = {s4_pch_reg, 32'd0} + {32'd0, s4_pcl_reg};
    assign zz30       = {s4_zz_reg, 30'd0};

    always_comb begin
        logic tl, th;
        tl = !s4_zero2_reg && (s4_inf_reg || (s4_pla_reg < s4_plb_reg));
        th = !s4_zero2_reg && (s4_inf_reg || (s4_pha_reg < s4_phb_reg));
        s5_ln_next = tl ? s4_lo2_reg : s4_ln_reg;
        s5_ld_next = tl ? s4_den2_reg : s4_ld_reg;
        s5_hn_next = th ? s4_hi2_reg : s4_hn_reg;
        s5_hd_next = th ? s4_den2_reg : s4_hd_reg;
    end

    // ---------------- S6: final slab cross products ----------------
    logic signed [65:0] s6_fl_reg, s6_fr_reg;
    logic               s6_inf_reg, s6_hpos_reg;
    logic [2:0]         s6_el_reg;
    logic [3:0]         s6_az_reg, s6_sg_reg;

    // ---------------- S7: result ----------------
    reason_t reason_next;
    logic    box_hit;
    reason_t out_reason_reg;

    assign box_hit = !miss_reg[6] && (s6_inf_reg || (s6_fl_reg < s6_fr_reg))
                     && (s6_inf_reg || s6_hpos_reg);

    always_comb begin
        reason_next = REASON_KEPT;
        if (!box_ready_reg && !arm_stowed_reg) begin
            reason_next = REASON_NOT_READY;
        end else if (s6_sg_reg[2] && ((s6_sg_reg[0] && s6_az_reg[0]) || s6_sg_reg[3])) begin
            reason_next = REASON_ARM;
        end else if (s6_sg_reg[2] && s6_sg_reg[0] && s6_az_reg[1] && s6_el_reg[0]) begin
            reason_next = REASON_BODY;
        end else if (s6_sg_reg[2] && s6_sg_reg[0] && s6_az_reg[1] && s6_az_reg[2]
                     && s6_el_reg[1]) begin
            reason_next = REASON_BASE;
        end else if (s6_sg_reg[2] && s6_sg_reg[1] && s6_az_reg[3] && s6_el_reg[2]) begin
            reason_next = REASON_CABLE;
        end else if (!arm_stowed_reg && box_hit) begin
            reason_next = REASON_BOX;
        end
    end

    assign m_tdata = {4'd0, tag_reg[7], out_reason_reg, (out_reason_reg == REASON_KEPT)};

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            // S0
            s0_p_reg[0] <= s_tdata[31:0];
            s0_p_reg[1] <= s_tdata[63:32];
            s0_p_reg[2] <= s_tdata[95:64];
            tag_reg[0]  <= s_tdata[111:96];
            for (int i = 1; i < 8; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
            for (int i = 2; i < 8; i++) begin
                miss_reg[i] <= miss_reg[i-1];
            end
            // S1
            s1_ax_reg    <= s1_ax_next;
            s1_ay_reg    <= s1_ay_next;
            s1_az_reg    <= s1_az_next;
            s1_lo_reg    <= s1_lo_next;
            s1_hi_reg    <= s1_hi_next;
            s1_den_reg   <= s1_den_next;
            s1_zero_reg  <= s1_zero_next;
            miss_reg[1]  <= s1_miss_next;
            s1_xpos_reg  <= !s0_p_reg[0][CW-1] && (s0_p_reg[0] != '0);
            s1_xneg_reg  <= s0_p_reg[0][CW-1];
            s1_zneg_reg  <= s0_p_reg[2][CW-1];
            // S2
            s2_xx_reg     <= s1_ax_reg * s1_ax_reg;
            s2_yy_reg     <= s1_ay_reg * s1_ay_reg;
            s2_zz_reg     <= s1_az_reg * s1_az_reg;
            s2_tarm_reg   <= TAN_ARM * s1_ax_reg;
            s2_tbody_reg  <= TAN_BODY * s1_ax_reg;
            s2_tbase_reg  <= TAN_BASE * s1_ax_reg;
            s2_tcable_reg <= TAN_CABLE * s1_ax_reg;
            s2_ay_reg     <= s1_ay_reg;
            s2_ln_reg     <= s1_lo_reg[0];
            s2_hn_reg     <= s1_hi_reg[0];
            s2_ld_reg     <= s1_den_reg[0];
            s2_hd_reg     <= s1_den_reg[0];
            s2_inf_reg    <= s1_zero_reg[0];
            s2_pla_reg    <= s1_lo_reg[0] * $signed({1'b0, s1_den_reg[1]});
            s2_plb_reg    <= s1_lo_reg[1] * $signed({1'b0, s1_den_reg[0]});
            s2_pha_reg    <= s1_hi_reg[1] * $signed({1'b0, s1_den_reg[0]});
            s2_phb_reg    <= s1_hi_reg[0] * $signed({1'b0, s1_den_reg[1]});
            s2_lo_reg     <= s1_lo_reg;
            s2_hi_reg     <= s1_hi_reg;
            s2_den_reg    <= s1_den_reg;
            s2_zero_reg   <= s1_zero_reg;
            s2_xpos_reg   <= s1_xpos_reg;
            s2_xneg_reg   <= s1_xneg_reg;
            s2_zneg_reg   <= s1_zneg_reg;
            s2_xyzero_reg <= s1_zero_reg[0] && s1_zero_reg[1];
            // S3
            s3_aarm_reg   <= s3_aarm_next;
            s3_abody_reg  <= s3_abody_next;
            s3_abase_reg  <= s3_abase_next;
            s3_acable_reg <= s3_acable_next;
            s3_rr_reg     <= s2_xx_reg + s2_yy_reg;
            s3_zz_reg     <= s2_zz_reg;
            s3_ln_reg     <= s3_ln_next;
            s3_ld_reg     <= s3_ld_next;
            s3_hn_reg     <= s3_hn_next;
            s3_hd_reg     <= s3_hd_next;
            s3_inf_reg    <= s2_inf_reg && s2_zero_reg[1];
            s3_lo2_reg    <= s2_lo_reg[2];
            s3_hi2_reg    <= s2_hi_reg[2];
            s3_den2_reg   <= s2_den_reg[2];
            s3_zero2_reg  <= s2_zero_reg[2];
            s3_xpos_reg   <= s2_xpos_reg;
            s3_xneg_reg   <= s2_xneg_reg;
            s3_zneg_reg   <= s2_zneg_reg;
            s3_xyzero_reg <= s2_xyzero_reg;
            // S4
            s4_pbh_reg   <= TSQ_BODY * s3_rr_reg[63:32];
            s4_pbl_reg   <= TSQ_BODY * s3_rr_reg[31:0];
            s4_pah_reg   <= TSQ_BASE * s3_rr_reg[63:32];
            s4_pal_reg   <= TSQ_BASE * s3_rr_reg[31:0];
            s4_pch_reg   <= TSQ_CABLE * s3_rr_reg[63:32];
            s4_pcl_reg   <= TSQ_CABLE * s3_rr_reg[31:0];
            s4_zz_reg    <= s3_zz_reg;
            s4_ln_reg    <= s3_ln_reg;
            s4_hn_reg    <= s3_hn_reg;
            s4_ld_reg    <= s3_ld_reg;
            s4_hd_reg    <= s3_hd_reg;
            s4_inf_reg   <= s3_inf_reg;
            s4_lo2_reg   <= s3_lo2_reg;
            s4_hi2_reg   <= s3_hi2_reg;
            s4_den2_reg  <= s3_den2_reg;
            s4_zero2_reg <= s3_zero2_reg;
            s4_pla_reg   <= s3_ln_reg * $signed({1'b0, s3_den2_reg});
            s4_plb_reg   <= s3_lo2_reg * $signed({1'b0, s3_ld_reg});
            s4_pha_reg   <= s3_hi2_reg * $signed({1'b0, s3_hd_reg});
            s4_phb_reg   <= s3_hn_reg * $signed({1'b0, s3_den2_reg});
            s4_az_reg    <= {s3_acable_reg, s3_abase_reg, s3_abody_reg, s3_aarm_reg};
            s4_sg_reg    <= {s3_xyzero_reg, s3_zneg_reg, s3_xneg_reg, s3_xpos_reg};
            // S5
            s5_el_reg  <= {({2'd0, prod_cable} < zz30), ({2'd0, prod_base} < zz30),
                           ({2'd0, prod_body} < zz30)};
            s5_az_reg  <= s4_az_reg;
            s5_sg_reg  <= s4_sg_reg;
            s5_ln_reg  <= s5_ln_next;
            s5_ld_reg  <= s5_ld_next;
            s5_hn_reg  <= s5_hn_next;
            s5_hd_reg  <= s5_hd_next;
            s5_inf_reg <= s4_inf_reg && s4_zero2_reg;
            // S6
            s6_fl_reg   <= s5_ln_reg * $signed({1'b0, s5_hd_reg});
            s6_fr_reg   <= s5_hn_reg * $signed({1'b0, s5_ld_reg});
            s6_inf_reg  <= s5_inf_reg;
            s6_hpos_reg <= s5_hn_reg > 0;
            s6_el_reg   <= s5_el_reg;
            s6_az_reg   <= s5_az_reg;
            s6_sg_reg   <= s5_sg_reg;
            // S7
            out_reason_reg <= reason_next;
        end
    end

    // ---------------- checks ----------------
    a_keep_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == REASON_KEPT)))
        else $error("keep flag disagrees with drop reason");

    a_reason_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] != 3'd7))
        else $error("drop reason out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved while result stalled");

endmodule

// File: sim/tb_lidar_point_mask_filter_unit.sv
// Testbench for lidar_point_mask_filter_unit: random and directed points, APB box setup.
// Depends on lpmf_pkg and the unit RTL; holds its own keep/drop predictor.
`timescale 1ns / 100ps

import lpmf_pkg::*;

typedef struct {
    logic    keep;
    reason_t why;
    logic [15:0] tag;
} verdict_t;

class mask_scoreboard;
    bit stowed = 1;
    bit ready = 0;
    longint bmin[3] = '{0, 0, 0};
    longint bmax[3] = '{0, 0, 0};
    verdict_t awaited[$];
    int mismatches = 0;
    int checked = 0;
    int reason_seen[7] = '{0, 0, 0, 0, 0, 0, 0};

    // |y|/x < tan (scaled by 2^30)
    function bit az_lt(longint ay, longint ax, longint tan30);
        logic [127:0] l, r;
        l = ay;
        l = l << 30;
        r = tan30;
        r = r * ax;
        return l < r;
    endfunction

    // elevation steeper than the angle whose tan^2 is tsq30
    function bit el_lt(logic [127:0] zz30, logic [127:0] rr, longint tsq30);
        logic [127:0] t;
        t = tsq30;
        return rr * t < zz30;
    endfunction

    // a/b < c/d, b and d positive
    function bit ratio_lt(longint a, longint b, longint c, longint d);
        logic signed [127:0] wa, wb, wc, wd;
        wa = a; wb = b; wc = c; wd = d;
        return wa * wd < wc * wb;
    endfunction

    function bit ray_hits_box(longint p[3]);
        bit lo_inf, hi_inf;
        longint ln, ld, hn, hd, n1, n2, den, lo, hi;
        lo_inf = 1; hi_inf = 1; ln = 0; ld = 1; hn = 0; hd = 1;
        for (int a = 0; a < 3; a++) begin
            if (p[a] == 0) begin
                // zero component: slab must contain the origin on this axis
                if (bmin[a] > 0 || bmax[a] < 0) return 0;
                continue;
            end
            n1 = p[a] > 0 ? bmin[a] : -bmin[a];
            n2 = p[a] > 0 ? bmax[a] : -bmax[a];
            den = p[a] > 0 ? p[a] : -p[a];
            lo = n1 < n2 ? n1 : n2;
            hi = n1 < n2 ? n2 : n1;
            if (lo_inf || ratio_lt(ln, ld, lo, den)) begin
                ln = lo; ld = den; lo_inf = 0;
            end
            if (hi_inf || ratio_lt(hi, den, hn, hd)) begin
                hn = hi; hd = den; hi_inf = 0;
            end
        end
        if (!(lo_inf || hi_inf || ratio_lt(ln, ld, hn, hd))) return 0;
        return hi_inf || hn > 0;
    endfunction

    function reason_t classify(longint x, longint y, longint z);
        longint ax, ay, az;
        logic [127:0] zz30, rr, t;
        longint p[3];
        if (!ready && !stowed) return REASON_NOT_READY;
        if (z < 0) begin
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            az = -z;
            zz30 = az;
            zz30 = (zz30 * zz30) << 30;
            rr = ax;
            t = ay;
            rr = rr * rr + t * t;
            if ((x > 0 && az_lt(ay, ax, TAN_ARM)) || (x == 0 && y == 0))
                return REASON_ARM;
            if (x > 0) begin
                if (az_lt(ay, ax, TAN_BODY)) begin
                    if (el_lt(zz30, rr, TSQ_BODY)) return REASON_BODY;
                    if (az_lt(ay, ax, TAN_BASE) && el_lt(zz30, rr, TSQ_BASE))
                        return REASON_BASE;
                end
            end else if (x < 0 && az_lt(ay, ax, TAN_CABLE) && el_lt(zz30, rr, TSQ_CABLE))
                return REASON_CABLE;
        end
        p[0] = x; p[1] = y; p[2] = z;
        if (!stowed && ray_hits_box(p)) return REASON_BOX;
        return REASON_KEPT;
    endfunction

    function void note_point(logic [111:0] d);
        verdict_t v;
        v.why = classify(longint'($signed(d[31:0])), longint'($signed(d[63:32])),
                         longint'($signed(d[95:64])));
        v.keep = (v.why == REASON_KEPT);
        v.tag = d[111:96];
        awaited.push_back(v);
    endfunction

    function void check_result(logic [23:0] d);
        verdict_t v;
        checked++;
        if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", d);
            return;
        end
        v = awaited.pop_front();
        reason_seen[v.why]++;
        if (d[0] !== v.keep || d[3:1] !== v.why || d[19:4] !== v.tag || d[23:20] !== 4'd0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp keep=%0d reason=%0d tag=%h, ",
                          "got keep=%0d reason=%0d tag=%h pad=%h"},
                         v.keep, v.why, v.tag, d[0], d[3:1], d[19:4], d[23:20]);
        end
    endfunction
endclass

module tb_lidar_point_mask_filter_unit;

    localparam int ONE_M = 1 << 16;     // 1 m in Q15.16
    localparam int STALL_LIMIT = 20000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;     // pos_x, pos_y, pos_z, point_tag (low to high)
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [23:0]  m_tdata;          // keep, drop_reason, tag_out, zero pad (low to high)
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    mask_scoreboard sb = new();
    int requests_sent = 0;   // drives the idling schedule
    int requests_taken = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_done = 0;
    int cfg_count = 0;

    lidar_point_mask_filter_unit dut (.*);

    always #2 aclk = ~aclk;

    // idling schedule: 0 sender light / receiver heavy, 1 swapped, 2 none
    function int idle_phase();
        if (requests_sent < 350) return 0;
        if (requests_sent < 700) return 1;
        return 2;
    endfunction

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_point(s_tdata);
                requests_taken++;
            end
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off to fill the pipe
    always @(posedge aclk) begin
        if (!hold_done && requests_taken >= 720) begin
            hold_done <= 1;
            hold_left <= 300;
            m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= (hold_left == 1);
        end else begin
            case (idle_phase())
                0: m_tready <= ($urandom_range(0, 99) >= 72);
                1: m_tready <= ($urandom_range(0, 99) >= 10);
                default: m_tready <= 1;
            endcase
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
        cfg_count++;
    endtask

    // arm state and box; bounds are signed Q15.16
    task automatic configure(bit stowed, bit ready, int mnx, int mny, int mnz,
                             int mxx, int mxy, int mxz);
        apb_write(REG_ARM_STOWED, {31'd0, stowed});
        apb_write(REG_BOX_READY, {31'd0, ready});
        apb_write(REG_BOX_MIN_X, mnx);
        apb_write(REG_BOX_MIN_Y, mny);
        apb_write(REG_BOX_MIN_Z, mnz);
        apb_write(REG_BOX_MAX_X, mxx);
        apb_write(REG_BOX_MAX_Y, mxy);
        apb_write(REG_BOX_MAX_Z, mxz);
        sb.stowed = stowed; sb.ready = ready;
        sb.bmin = '{mnx, mny, mnz};
        sb.bmax = '{mxx, mxy, mxz};
    endtask

    task automatic send_point(int x, int y, int z, logic [15:0] tag);
        int p;
        p = idle_phase() == 0 ? 10 : (idle_phase() == 1 ? 72 : 0);
        if ($urandom_range(0, 99) < p) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {tag, z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // mostly points within a few metres, some steep downward, some raw noise
    task automatic send_random(int n);
        int x, y, z, r;
        repeat (n) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                x = $urandom; y = $urandom; z = $urandom;
            end else if (r == 2) begin
                x = pick_extreme(); y = pick_extreme(); z = pick_extreme();
            end else begin
                x = int'($urandom_range(0, 8 * ONE_M)) - 4 * ONE_M;
                y = int'($urandom_range(0, 8 * ONE_M)) - 4 * ONE_M;
                if (r >= 6) y = y / int'($urandom_range(1, 16));
                if (r >= 5) begin
                    z = (x < 0 ? -x : x) * int'($urandom_range(0, 12)) / 8;
                    z = -z - int'($urandom_range(0, ONE_M));
                end else
                    z = int'($urandom_range(0, 8 * ONE_M)) - 4 * ONE_M;
            end
            send_point(x, y, z, 16'($urandom));
        end
    endtask

    // idle the input and let the pipe empty before touching registers
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset values: stowed, no box; angular masks only
        send_point(1000, 10, -1, 16'h0000);                 // arm wedge
        send_point(1000, 100, -2000, 16'hffff);             // arm wedge
        send_point(1000, 200, -400, 16'h1234);              // arm base
        send_point(-1000, 100, -1000, 16'h4321);            // rear cable
        send_point(0, 0, -1, 16'h0001);                     // straight down
        send_point(0, 0, 0, 16'h0002);                      // origin
        send_point(1000, 10, 5, 16'h0003);                  // upper half
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h8000);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h7fff);
        send_point(32'h7fff_ffff, 0, 32'h8000_0000, 16'h00ff);
        send_point(32'h8000_0000, 32'h7fff_ffff, -1, 16'hff00);
        send_point(-1000, 0, -1000, 16'h5555);
        send_point(1000, -300, -3000, 16'haaaa);
        send_random(100);
        drain();

        // deployed but box not ready: everything dropped
        configure(0, 0, 0, 0, 0, 0, 0, 0);
        send_random(30);
        drain();

        // box ahead and below the sensor
        configure(0, 1, ONE_M / 2, -ONE_M / 2, -2 * ONE_M, 2 * ONE_M, ONE_M / 2, -ONE_M / 5);
        send_point(ONE_M, 0, -ONE_M / 2, 16'h0010);         // through the box
        send_point(ONE_M, 0, 0, 16'h0011);                  // zero z outside z slab
        send_point(0, 0, 0, 16'h0012);                      // origin, box excludes it
        send_random(300);
        drain();

        // full-range box, contains everything
        configure(0, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(0, 0, 0, 16'h0020);
        send_random(200);
        drain();

        // swapped bounds around the origin
        configure(0, 1, 2 * ONE_M, ONE_M, ONE_M, -2 * ONE_M, -ONE_M, -ONE_M);
        send_point(0, 0, 0, 16'h0030);
        send_point(ONE_M, ONE_M, ONE_M, 16'h0031);
        send_random(200);
        drain();

        // stowed with a valid box: box ignored
        configure(1, 1, -ONE_M, -ONE_M, -ONE_M, ONE_M, ONE_M, ONE_M);
        send_random(200);
        drain();

        $display("run covered %0d point requests, %0d results, %0d register writes",
                 requests_sent, sb.checked, cfg_count);
        $display("results by reason kept/notready/arm/body/base/cable/box: %0d %0d %0d %0d %0d %0d %0d",
                 sb.reason_seen[0], sb.reason_seen[1], sb.reason_seen[2], sb.reason_seen[3],
                 sb.reason_seen[4], sb.reason_seen[5], sb.reason_seen[6]);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("tb: success");
        else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.awaited.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
